@@ sv/askp_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// askp_pkg
// Shared widths, codes and register indexes of the ADC scan ladder keypad.
// ============================================================================
package askp_pkg;

   // Converter and keypad sizing
   localparam int SAMPLE_BITS   = 10;
   localparam int BUTTON_COUNT  = 5;
   localparam int CODE_BITS     = 3;
   localparam int MUX_BITS      = 3;
   localparam int SLOT_COUNT    = 4;
   localparam int SLOT_BITS     = 2;
   localparam int BAND_BITS     = 2 * SAMPLE_BITS;
   localparam int MUX_REG_BITS  = MUX_BITS * SLOT_COUNT;
   localparam int CSR_DATA_BITS = (BAND_BITS > MUX_REG_BITS) ? BAND_BITS : MUX_REG_BITS;
   localparam int CSR_IDX_BITS  = 3;

   // Button codes
   localparam logic [CODE_BITS-1:0] CODE_NONE = CODE_BITS'(0);
   localparam logic [CODE_BITS-1:0] CODE_ONE  = CODE_BITS'(1);
   localparam logic [CODE_BITS-1:0] CODE_TWO  = CODE_BITS'(2);
   localparam logic [CODE_BITS-1:0] CODE_THREE = CODE_BITS'(3);
   localparam logic [CODE_BITS-1:0] CODE_FOUR = CODE_BITS'(4);
   localparam logic [CODE_BITS-1:0] CODE_OFF  = CODE_BITS'(5);

   // Reset value of the off threshold: all ones
   localparam logic [SAMPLE_BITS-1:0] OFF_LOW_RESET = {SAMPLE_BITS{1'b1}};

   // Scan slots
   typedef enum logic [SLOT_BITS-1:0] {
      SLOT_STEER  = 2'd0,
      SLOT_MOTOR  = 2'd1,
      SLOT_BRAKE  = 2'd2,
      SLOT_BUTTON = 2'd3
   } slot_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_OFF_LOW    = 3'd0,
      REG_BAND_FOUR  = 3'd1,
      REG_BAND_THREE = 3'd2,
      REG_BAND_TWO   = 3'd3,
      REG_BAND_ONE   = 3'd4,
      REG_MUX_CODES  = 3'd5
   } csr_index_type;

endpackage

@@ sv/adc_scan_ladder_keypad.sv @@
`timescale 1ns / 1ps
// ============================================================================
// adc_scan_ladder_keypad
// Round-robin ADC slot tracker with resistor-ladder keypad decode.
// ============================================================================
// A result is registered for the cycle after acceptance. Throughput: one
// request per cycle while no result stalls; decode is a handful of compares
// ahead of the single result register, and toggle state updates with it.
// Reset (synchronous): slot back to steer, no last button, toggles cleared,
// registers at their reset values, no result pending.
module adc_scan_ladder_keypad
   import askp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [SAMPLE_BITS-1:0]   req_sample,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [SLOT_BITS-1:0]     rsp_sampled_slot,
   output logic [SAMPLE_BITS-1:0]   rsp_sample_value,
   output logic [MUX_BITS-1:0]      rsp_next_mux,
   output logic                     rsp_button_event,
   output logic [CODE_BITS-1:0]     rsp_pressed_button,
   output logic                     rsp_toggle_state,
   output logic                     rsp_sleep_request,
   // configuration write channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // Configuration registers
   logic [SAMPLE_BITS-1:0]  off_low_ff;
   logic [BAND_BITS-1:0]    band_ff [4];   // 0 four, 1 three, 2 two, 3 one
   logic [MUX_REG_BITS-1:0] mux_codes_ff;

   // Scan and keypad state
   slot_type                slot_ff, slot_in;
   logic [CODE_BITS-1:0]    last_button_ff, last_button_in;
   logic [BUTTON_COUNT-1:0] toggles_ff, toggles_in;

   // Result register
   logic                    rsp_valid_ff;
   logic [SLOT_BITS-1:0]    slot_out_ff, slot_out_in;
   logic [SAMPLE_BITS-1:0]  value_ff;
   logic [MUX_BITS-1:0]     next_mux_ff, next_mux_in;
   logic                    event_ff, event_in;
   logic [CODE_BITS-1:0]    pressed_ff, pressed_in;
   logic                    toggle_ff, toggle_in;
   logic                    sleep_ff, sleep_in;

   logic                    accept;
   logic [CODE_BITS-1:0]    code;
   logic [3:0]              band_hit;
   slot_type                next_slot;
   logic                    flip;

   // Handshakes
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   // Inclusive window compares for the four bands
   always_comb begin
      for (int b = 0; b < 4; b++) begin
         band_hit[b] = (req_sample >= band_ff[b][SAMPLE_BITS-1:0]) &&
                       (req_sample <= band_ff[b][BAND_BITS-1:SAMPLE_BITS]);
      end
   end

   // Priority decode: off threshold, then four down to one
   always_comb begin
      if (req_sample > off_low_ff)  code = CODE_OFF;
      else if (band_hit[0])         code = CODE_FOUR;
      else if (band_hit[1])         code = CODE_THREE;
      else if (band_hit[2])         code = CODE_TWO;
      else if (band_hit[3])         code = CODE_ONE;
      else                          code = CODE_NONE;
   end

   // Next slot and its mux code
   assign next_slot = slot_type'(slot_ff + 2'd1);

   always_comb begin
      case (next_slot)
         SLOT_STEER:  next_mux_in = mux_codes_ff[0*MUX_BITS +: MUX_BITS];
         SLOT_MOTOR:  next_mux_in = mux_codes_ff[1*MUX_BITS +: MUX_BITS];
         SLOT_BRAKE:  next_mux_in = mux_codes_ff[2*MUX_BITS +: MUX_BITS];
         SLOT_BUTTON: next_mux_in = mux_codes_ff[3*MUX_BITS +: MUX_BITS];
         default:     next_mux_in = mux_codes_ff[0*MUX_BITS +: MUX_BITS];
      endcase
   end

   // Keypad tracking: new nonzero in-range code flips its toggle
   always_comb begin
      slot_in        = next_slot;
      slot_out_in    = slot_ff;
      last_button_in = last_button_ff;
      toggles_in     = toggles_ff;
      pressed_in     = CODE_NONE;
      event_in       = 1'b0;
      toggle_in      = 1'b0;
      sleep_in       = 1'b0;
      flip           = 1'b0;
      if (slot_ff == SLOT_BUTTON) begin
         pressed_in = code;
         if (code != last_button_ff) begin
            last_button_in = code;
            flip = (code != CODE_NONE) &&
                   ({1'b0, code} <= (CODE_BITS+1)'(BUTTON_COUNT));
         end
      end
      for (int i = 0; i < BUTTON_COUNT; i++) begin
         if (flip && (code == CODE_BITS'(i + 1))) begin
            toggles_in[i] = ~toggles_ff[i];
            toggle_in     = ~toggles_ff[i];
         end
      end
      event_in = flip;
      sleep_in = flip && (code == CODE_OFF) && toggle_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         off_low_ff   <= OFF_LOW_RESET;
         band_ff[0]   <= '0;
         band_ff[1]   <= '0;
         band_ff[2]   <= '0;
         band_ff[3]   <= '0;
         mux_codes_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            REG_OFF_LOW:    off_low_ff   <= csr_wdata[SAMPLE_BITS-1:0];
            REG_BAND_FOUR:  band_ff[0]   <= csr_wdata[BAND_BITS-1:0];
            REG_BAND_THREE: band_ff[1]   <= csr_wdata[BAND_BITS-1:0];
            REG_BAND_TWO:   band_ff[2]   <= csr_wdata[BAND_BITS-1:0];
            REG_BAND_ONE:   band_ff[3]   <= csr_wdata[BAND_BITS-1:0];
            REG_MUX_CODES:  mux_codes_ff <= csr_wdata[MUX_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   // State and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff        <= SLOT_STEER;
         last_button_ff <= CODE_NONE;
         toggles_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            slot_ff        <= slot_in;
            last_button_ff <= last_button_in;
            toggles_ff     <= toggles_in;
            rsp_valid_ff   <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         slot_out_ff <= slot_out_in;
         value_ff    <= req_sample;
         next_mux_ff <= next_mux_in;
         event_ff    <= event_in;
         pressed_ff  <= pressed_in;
         toggle_ff   <= toggle_in;
         sleep_ff    <= sleep_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sampled_slot   = slot_out_ff;
   assign rsp_sample_value   = value_ff;
   assign rsp_next_mux       = next_mux_ff;
   assign rsp_button_event   = event_ff;
   assign rsp_pressed_button = pressed_ff;
   assign rsp_toggle_state   = toggle_ff;
   assign rsp_sleep_request  = sleep_ff;

endmodule

@@ sv/askp_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// askp_checker
// Port-level checks of the ADC scan ladder keypad, bound to the top level.
// ============================================================================
module askp_checker
   import askp_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [SLOT_BITS-1:0]   rsp_sampled_slot,
   input logic [SAMPLE_BITS-1:0] rsp_sample_value,
   input logic                   rsp_button_event,
   input logic [CODE_BITS-1:0]   rsp_pressed_button,
   input logic                   rsp_toggle_state,
   input logic                   rsp_sleep_request
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_value) &&
                                 $stable(rsp_sampled_slot))
      else $error("stalled result changed");

   // An accepted request always yields a result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no result");

   // Non-button slots carry no keypad activity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_sampled_slot != SLOT_BUTTON) |->
         !rsp_button_event && !rsp_toggle_state && !rsp_sleep_request &&
         (rsp_pressed_button == CODE_NONE))
      else $error("keypad activity on a non-button slot");

   // Sleep only comes from the off button toggling to active
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sleep_request |->
         rsp_button_event && rsp_toggle_state && (rsp_pressed_button == CODE_OFF))
      else $error("sleep request without off-button toggle");

endmodule

bind adc_scan_ladder_keypad askp_checker u_askp_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_sampled_slot   (rsp_sampled_slot),
   .rsp_sample_value   (rsp_sample_value),
   .rsp_button_event   (rsp_button_event),
   .rsp_pressed_button (rsp_pressed_button),
   .rsp_toggle_state   (rsp_toggle_state),
   .rsp_sleep_request  (rsp_sleep_request)
);

@@ dv/keypad_scan_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// keypad_scan_checker
// Watches the request, result and register channels of the ADC scan ladder
// keypad, predicts every result from its own copy of the scan state and the
// window table, and compares each accepted result field by field.
// ============================================================================
module keypad_scan_checker
   import askp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [SAMPLE_BITS-1:0]   req_sample,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [SLOT_BITS-1:0]     rsp_sampled_slot,
   input  logic [SAMPLE_BITS-1:0]   rsp_sample_value,
   input  logic [MUX_BITS-1:0]      rsp_next_mux,
   input  logic                     rsp_button_event,
   input  logic [CODE_BITS-1:0]     rsp_pressed_button,
   input  logic                     rsp_toggle_state,
   input  logic                     rsp_sleep_request,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output int                       fail_count,
   output int                       pending_count,
   output int                       event_count,
   output int                       sleep_count
);

   typedef struct packed {
      logic [SLOT_BITS-1:0]   slot;
      logic [SAMPLE_BITS-1:0] value;
      logic [MUX_BITS-1:0]    mux;
      logic                   event_flag;
      logic [CODE_BITS-1:0]   button;
      logic                   toggle;
      logic                   sleep;
   } scan_result_type;

   scan_result_type scan_results_due [$];

   // Shadow registers and scan state
   logic [SAMPLE_BITS-1:0]  off_low_q;
   logic [BAND_BITS-1:0]    band_q [1:4];
   logic [MUX_REG_BITS-1:0] mux_q;
   slot_type                slot_q;
   logic [CODE_BITS-1:0]    last_code_q;
   logic [BUTTON_COUNT:1]   toggle_q;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      event_count   = 0;
      sleep_count   = 0;
   end

   // Inclusive window, low in the lower half, high in the upper half
   function automatic logic in_window(input logic [SAMPLE_BITS-1:0] s,
                                      input logic [BAND_BITS-1:0] w);
      return (s >= w[SAMPLE_BITS-1:0]) && (s <= w[BAND_BITS-1:SAMPLE_BITS]);
   endfunction

   // Ladder decode, off threshold first, then bands four down to one
   function automatic logic [CODE_BITS-1:0] ladder_code(input logic [SAMPLE_BITS-1:0] s);
      if (s > off_low_q) return CODE_OFF;
      if (in_window(s, band_q[4])) return CODE_FOUR;
      if (in_window(s, band_q[3])) return CODE_THREE;
      if (in_window(s, band_q[2])) return CODE_TWO;
      if (in_window(s, band_q[1])) return CODE_ONE;
      return CODE_NONE;
   endfunction

   // Advance the scan by one conversion and queue the result it yields
   task automatic predict_scan(input logic [SAMPLE_BITS-1:0] s);
      scan_result_type      r;
      logic [SLOT_BITS-1:0] nxt;
      logic [CODE_BITS-1:0] code;
      nxt     = slot_q + 1'b1;
      r       = '0;
      r.slot  = slot_q;
      r.value = s;
      r.mux   = mux_q[MUX_BITS*nxt +: MUX_BITS];
      if (slot_q == SLOT_BUTTON) begin
         code     = ladder_code(s);
         r.button = code;
         if (code != last_code_q) begin
            // only a fresh, valid press flips its toggle
            if (code != CODE_NONE && code <= BUTTON_COUNT) begin
               toggle_q[code] = ~toggle_q[code];
               r.event_flag   = 1'b1;
               r.toggle       = toggle_q[code];
               r.sleep        = (code == CODE_OFF) && toggle_q[code];
            end
            last_code_q = code;
         end
      end
      slot_q = slot_type'(nxt);
      scan_results_due.push_back(r);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic compare_result();
      scan_result_type r;
      if (scan_results_due.size() == 0) begin
         $display("%0t: result with no request waiting, expected none, got slot %0d",
                  $time, rsp_sampled_slot);
         fail_count++;
      end else begin
         r = scan_results_due.pop_front();
         check_field("sampled_slot", r.slot, rsp_sampled_slot);
         check_field("sample_value", r.value, rsp_sample_value);
         check_field("next_mux", r.mux, rsp_next_mux);
         check_field("button_event", r.event_flag, rsp_button_event);
         check_field("pressed_button", r.button, rsp_pressed_button);
         check_field("toggle_state", r.toggle, rsp_toggle_state);
         check_field("sleep_request", r.sleep, rsp_sleep_request);
         if (r.event_flag) event_count++;
         if (r.sleep) sleep_count++;
      end
   endtask

   // Sample all channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         off_low_q   = OFF_LOW_RESET;
         band_q[1]   = '0;
         band_q[2]   = '0;
         band_q[3]   = '0;
         band_q[4]   = '0;
         mux_q       = '0;
         slot_q      = SLOT_STEER;
         last_code_q = CODE_NONE;
         toggle_q    = '0;
         scan_results_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_OFF_LOW:    off_low_q = csr_wdata[SAMPLE_BITS-1:0];
               REG_BAND_FOUR:  band_q[4] = csr_wdata[BAND_BITS-1:0];
               REG_BAND_THREE: band_q[3] = csr_wdata[BAND_BITS-1:0];
               REG_BAND_TWO:   band_q[2] = csr_wdata[BAND_BITS-1:0];
               REG_BAND_ONE:   band_q[1] = csr_wdata[BAND_BITS-1:0];
               REG_MUX_CODES:  mux_q     = csr_wdata[MUX_REG_BITS-1:0];
               default: ;
            endcase
         end
         // result first: it belongs to an earlier request
         if (rsp_valid && !rsp_stall) compare_result();
         if (req_valid && !req_stall) predict_scan(req_sample);
      end
      pending_count = scan_results_due.size();
   end

endmodule

@@ dv/tb_adc_scan_ladder_keypad.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_adc_scan_ladder_keypad
// Drives conversions and window-table settings into the ADC scan ladder
// keypad: a directed pass over decode priority, repeats, releases and the
// off toggle, then random phases of press/hold/release sequences under
// changing tables and flow-control pressure. A checker predicts and compares.
// ============================================================================
module tb_adc_scan_ladder_keypad;
   import askp_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 250;
   localparam int PHASE_COUNT  = 7;
   localparam int HOLD_CYCLES  = 60;
   localparam logic [CSR_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [SAMPLE_BITS-1:0]   req_sample = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [SLOT_BITS-1:0]     rsp_sampled_slot;
   logic [SAMPLE_BITS-1:0]   rsp_sample_value;
   logic [MUX_BITS-1:0]      rsp_next_mux;
   logic                     rsp_button_event;
   logic [CODE_BITS-1:0]     rsp_pressed_button;
   logic                     rsp_toggle_state;
   logic                     rsp_sleep_request;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   int fail_count, pending_count, event_count, sleep_count;

   // Stimulus-side knowledge of the table, used to aim button samples
   logic [SAMPLE_BITS-1:0] off_cfg = OFF_LOW_RESET;
   logic [BAND_BITS-1:0]   band_cfg [1:4];
   logic [SAMPLE_BITS-1:0] held_sample = '0;

   int scan_pos      = 0;
   int request_count = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int cycle_count   = 0;

   logic [SAMPLE_BITS-1:0] press_seq [6] = '{10'd1023, 10'd1023, 10'd0,
                                             10'd1023, 10'd720, 10'd400};
   logic [SAMPLE_BITS-1:0] rail_seq  [4] = '{10'h000, 10'h3FF, 10'h155, 10'h2AA};

   adc_scan_ladder_keypad DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sampled_slot   (rsp_sampled_slot),
      .rsp_sample_value   (rsp_sample_value),
      .rsp_next_mux       (rsp_next_mux),
      .rsp_button_event   (rsp_button_event),
      .rsp_pressed_button (rsp_pressed_button),
      .rsp_toggle_state   (rsp_toggle_state),
      .rsp_sleep_request  (rsp_sleep_request),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   keypad_scan_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sampled_slot   (rsp_sampled_slot),
      .rsp_sample_value   (rsp_sample_value),
      .rsp_next_mux       (rsp_next_mux),
      .rsp_button_event   (rsp_button_event),
      .rsp_pressed_button (rsp_pressed_button),
      .rsp_toggle_state   (rsp_toggle_state),
      .rsp_sleep_request  (rsp_sleep_request),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .event_count        (event_count),
      .sleep_count        (sleep_count)
   );

   // Clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_count);
         $display("tb: failure");
         $finish;
      end
   end

   // Result side: random stalls, plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_stall   <= 1'b1;
         hold_served <= hold_served + 1;
         hold_left   <= HOLD_CYCLES;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // One request, with random idle cycles ahead of it
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      scan_pos++;
      request_count++;
   endtask

   // Stop offering and wait until every result is back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_OFF_LOW:    off_cfg     = data[SAMPLE_BITS-1:0];
         REG_BAND_FOUR:  band_cfg[4] = data[BAND_BITS-1:0];
         REG_BAND_THREE: band_cfg[3] = data[BAND_BITS-1:0];
         REG_BAND_TWO:   band_cfg[2] = data[BAND_BITS-1:0];
         REG_BAND_ONE:   band_cfg[1] = data[BAND_BITS-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [BAND_BITS-1:0] pack_band(input int lo, input int hi);
      return {SAMPLE_BITS'(hi), SAMPLE_BITS'(lo)};
   endfunction

   // Full table write; the two spare indexes get noise that must be ignored
   task automatic load_table(input logic [SAMPLE_BITS-1:0] off,
                             input logic [BAND_BITS-1:0] b4, input logic [BAND_BITS-1:0] b3,
                             input logic [BAND_BITS-1:0] b2, input logic [BAND_BITS-1:0] b1,
                             input logic [MUX_REG_BITS-1:0] mux);
      write_reg(REG_SPARE_LO, CSR_DATA_BITS'($urandom));
      write_reg(REG_OFF_LOW, CSR_DATA_BITS'(off));
      write_reg(REG_BAND_FOUR, b4);
      write_reg(REG_BAND_THREE, b3);
      write_reg(REG_BAND_TWO, b2);
      write_reg(REG_BAND_ONE, b1);
      write_reg(REG_MUX_CODES, CSR_DATA_BITS'(mux));
      write_reg(REG_SPARE_HI, CSR_DATA_BITS'($urandom));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random window, mostly ordered, sometimes inverted or raw bits
   function automatic logic [BAND_BITS-1:0] random_band();
      int lo, hi, t;
      lo = $urandom_range(0, 1023);
      hi = $urandom_range(0, 1023);
      if ($urandom_range(0, 9) < 2) return BAND_BITS'($urandom);
      if ($urandom_range(0, 9) < 8 && lo > hi) begin
         t  = lo;
         lo = hi;
         hi = t;
      end
      return pack_band(lo, hi);
   endfunction

   // Button-slot sample: hold, aim at a window (often its edges), or noise
   function automatic logic [SAMPLE_BITS-1:0] next_button_sample();
      int r, target, lo, hi;
      r = $urandom_range(0, 99);
      if (r < 30) return held_sample;
      if (r < 50) begin
         held_sample = SAMPLE_BITS'($urandom);
         return held_sample;
      end
      target = $urandom_range(0, 5);
      if (target == CODE_OFF) begin
         lo = (off_cfg == OFF_LOW_RESET) ? 0 : off_cfg + 1;
         hi = 1023;
      end else if (target == CODE_NONE) begin
         lo = 0;
         hi = 1023;
      end else begin
         lo = band_cfg[target][SAMPLE_BITS-1:0];
         hi = band_cfg[target][BAND_BITS-1:SAMPLE_BITS];
      end
      case ($urandom_range(0, 4))
         0:       held_sample = SAMPLE_BITS'(lo);
         1:       held_sample = SAMPLE_BITS'(hi);
         default: held_sample = SAMPLE_BITS'($urandom_range(lo, hi));
      endcase
      return held_sample;
   endfunction

   task automatic set_idle_mode(input int phase);
      case (phase % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 63; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 63; end
         default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
   endtask

   initial begin
      band_cfg[1] = '0;
      band_cfg[2] = '0;
      band_cfg[3] = '0;
      band_cfg[4] = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Reset table: sample zero on the button slot falls in band four
      send_sample(10'd0);
      send_sample(10'd1023);
      send_sample(10'd512);
      send_sample(10'd0);
      drain();

      // Directed table: bands three and four overlap, band two inverted
      load_table(10'd900, pack_band(700, 850), pack_band(500, 750),
                 pack_band(499, 300), pack_band(100, 299), 12'b110_011_101_001);
      // off press and sleep, repeat, release, off again, overlap, dead band
      for (int g = 0; g < 6; g++) begin
         for (int k = 0; k < 3; k++) send_sample(rail_seq[(g + k) % 4]);
         send_sample(press_seq[g]);
      end

      // Random phases under changing tables and flow control
      for (int phase = 1; phase <= PHASE_COUNT; phase++) begin
         drain();
         case (phase)
            1: load_table(10'd0, {BAND_BITS{1'b1}}, {BAND_BITS{1'b1}},
                          {BAND_BITS{1'b1}}, {BAND_BITS{1'b1}}, {MUX_REG_BITS{1'b1}});
            2: load_table(OFF_LOW_RESET, '0, '0, '0, '0, '0);
            default: load_table(SAMPLE_BITS'($urandom_range(0, 1023)), random_band(),
                                random_band(), random_band(), random_band(),
                                MUX_REG_BITS'($urandom));
         endcase
         set_idle_mode(phase);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ((phase == 4 || phase == 6) && n == 60) hold_requests++;
            if (phase == 3 && n == PHASE_ITEMS / 2) drain();
            if (scan_pos % 4 == SLOT_BUTTON)
               send_sample(next_button_sample());
            else
               send_sample(SAMPLE_BITS'($urandom));
         end
      end

      drain();
      $display("summary: %0d requests over %0d table phases, %0d button events, %0d sleep requests",
               request_count, PHASE_COUNT + 2, event_count, sleep_count);
      $display("summary: %0d mismatches found", fail_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
